// File: rtl/bse_pkg.sv
// Shared types and constants for the bubble sort engine.
// No dependencies; compile first.
package bse_pkg;

   localparam int MAX_ELEMENTS_DEF = 16;
   localparam int VALUE_W          = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_batch;
      logic                      overflow;
   } rsp_payload_type;

endpackage

// File: rtl/bse_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Depends on bse_pkg for the payload types handed in as a type parameter.
interface bse_stream_if #(
   parameter type payload_type = bse_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/bubble_sort_engine_unit.sv
// Batch sorter: signed 32-bit values in, ascending sorted values out.
// Depends on bse_pkg (types, defaults) and bse_stream_if (channels).
//
// The block stores up to MAX_ELEMENTS values per batch in one memory with a
// registered read port; the beat marked last closes the batch, the stored values
// are bubble sorted in place and then streamed out, the final beat flagged
// end_of_batch. Values that arrive when the store is full are dropped and every
// output beat of that batch then carries overflow. Loading accepts one input
// beat per cycle; a sort pass reads its live entries one a cycle through the
// single read port, writes the smaller of each registered read and the carried
// maximum back one entry lower, and writes the final maximum back in ST_PASS_END;
// passes shrink by one entry and stop after the first pass without a swap or after
// a pass over two entries. Emitting issues a new read only once the previous one
// has landed and the one-entry output register is free or being handed over.
// Input is taken only while loading, but loading of the next batch starts as soon
// as the last read of the previous batch has been issued, while its last results
// still wait in the output register. No clearing pass after reset.
module bubble_sort_engine_unit #(
   parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bse_stream_if.sink   req_chan,
   bse_stream_if.source rsp_chan
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_ZERO = '0;

   typedef enum logic [3:0] {
      ST_LOAD     = 4'b0001,
      ST_SORT     = 4'b0010,
      ST_PASS_END = 4'b0100,
      ST_EMIT     = 4'b1000
   } state_type;

   // Control state
   state_type           state_ff,    state_in;
   logic [CNT_W-1:0]    count_ff,    count_in;     // stored elements this batch
   logic                dropped_ff,  dropped_in;   // batch overflowed
   logic [CNT_W-1:0]    limit_ff,    limit_in;     // live entries of this pass
   logic [CNT_W-1:0]    rd_idx_ff,   rd_idx_in;    // next entry to read in a pass
   logic                rvld_ff,     rvld_in;      // read data of a pass is valid
   logic [CNT_W-1:0]    ridx_ff,     ridx_in;      // entry that read data belongs to
   logic                swapped_ff,  swapped_in;
   logic [CNT_W-1:0]    emit_idx_ff, emit_idx_in;
   logic                infl_ff,     infl_in;      // emit read in flight
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic signed [bse_pkg::VALUE_W-1:0] carry_ff, carry_in;   // running maximum
   logic                               infl_last_ff, infl_last_in;
   logic                               infl_ovf_ff,  infl_ovf_in;
   bse_pkg::rsp_payload_type           rsp_pay_ff,   rsp_pay_in;

   // Element store
   logic signed [bse_pkg::VALUE_W-1:0] mem [MAX_ELEMENTS];
   logic signed [bse_pkg::VALUE_W-1:0] rdata_ff;
   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic signed [bse_pkg::VALUE_W-1:0] wr_data;
   logic                               rd_en;
   logic [IDX_W-1:0]                   rd_addr;

   logic             req_fire;
   logic             rsp_fire;
   logic             has_room;
   logic [CNT_W-1:0] count_next_load;
   logic [CNT_W-1:0] ridx_prev;
   logic [CNT_W-1:0] limit_m1;
   logic [CNT_W-1:0] count_m1;
   logic             do_swap;
   logic             issue;
   logic             emit_issue;

   assign req_chan.ready   = (state_ff == ST_LOAD);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_pay_ff;
   assign rsp_fire         = rsp_valid_ff && rsp_chan.ready;

   assign has_room        = (count_ff < MAX_CNT);
   assign count_next_load = has_room ? (count_ff + CNT_ONE) : count_ff;
   assign ridx_prev       = ridx_ff - CNT_ONE;
   assign limit_m1        = limit_ff - CNT_ONE;
   assign count_m1        = count_ff - CNT_ONE;
   // Strictly greater: equal values stay put, which keeps the sort stable.
   assign do_swap         = (carry_ff > rdata_ff);
   assign issue           = (state_ff == ST_SORT) && (rd_idx_ff < limit_ff);
   // Issue an emit read only if the output register is free by the time data lands.
   assign emit_issue      = (state_ff == ST_EMIT) && !infl_ff && (!rsp_valid_ff || rsp_fire);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      limit_in     = limit_ff;
      rd_idx_in    = rd_idx_ff;
      rvld_in      = issue;
      ridx_in      = rd_idx_ff;
      swapped_in   = swapped_ff;
      emit_idx_in  = emit_idx_ff;
      infl_in      = emit_issue;
      infl_last_in = infl_last_ff;
      infl_ovf_in  = infl_ovf_ff;
      carry_in     = carry_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_chan.payload.value;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // Store while there is room, otherwise drop and flag the batch.
               if (has_room) begin
                  wr_en    = 1'b1;
                  count_in = count_next_load;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.payload.last) begin
                  limit_in    = count_next_load;
                  rd_idx_in   = CNT_ZERO;
                  swapped_in  = 1'b0;
                  emit_idx_in = CNT_ZERO;
                  state_in    = (count_next_load < CNT_TWO) ? ST_EMIT : ST_SORT;
               end
            end
         end

         ST_SORT: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_ONE;
            end
            if (rvld_ff) begin
               if (ridx_ff == CNT_ZERO) begin
                  carry_in = rdata_ff;
               end else begin
                  // Write the smaller one back, carry the larger one onwards.
                  wr_en      = 1'b1;
                  wr_addr    = ridx_prev[IDX_W-1:0];
                  wr_data    = do_swap ? rdata_ff : carry_ff;
                  carry_in   = do_swap ? carry_ff : rdata_ff;
                  swapped_in = swapped_ff || do_swap;
               end
               if (ridx_ff == limit_m1) begin
                  state_in = ST_PASS_END;
               end
            end
         end

         ST_PASS_END: begin
            // Park the pass maximum at the top of the live range.
            wr_en   = 1'b1;
            wr_addr = limit_m1[IDX_W-1:0];
            wr_data = carry_ff;
            if (swapped_ff && (limit_ff > CNT_TWO)) begin
               limit_in   = limit_m1;
               rd_idx_in  = CNT_ZERO;
               swapped_in = 1'b0;
               state_in   = ST_SORT;
            end else begin
               emit_idx_in = CNT_ZERO;
               state_in    = ST_EMIT;
            end
         end

         ST_EMIT: begin
            rd_addr = emit_idx_ff[IDX_W-1:0];
            if (emit_issue) begin
               rd_en        = 1'b1;
               emit_idx_in  = emit_idx_ff + CNT_ONE;
               infl_last_in = (emit_idx_ff == count_m1);
               infl_ovf_in  = dropped_ff;
               if (emit_idx_ff == count_m1) begin
                  // Last read issued: open the next batch straight away.
                  count_in   = CNT_ZERO;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Output register: load from read data when an emit read lands, drop on handshake.
   always_comb begin
      rsp_pay_in   = rsp_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      if (infl_ff) begin
         rsp_pay_in.sorted_value = rdata_ff;
         rsp_pay_in.end_of_batch = infl_last_ff;
         rsp_pay_in.overflow     = infl_ovf_ff;
         rsp_valid_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         limit_ff     <= '0;
         rd_idx_ff    <= '0;
         rvld_ff      <= 1'b0;
         ridx_ff      <= '0;
         swapped_ff   <= 1'b0;
         emit_idx_ff  <= '0;
         infl_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         limit_ff     <= limit_in;
         rd_idx_ff    <= rd_idx_in;
         rvld_ff      <= rvld_in;
         ridx_ff      <= ridx_in;
         swapped_ff   <= swapped_in;
         emit_idx_ff  <= emit_idx_in;
         infl_ff      <= infl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff     <= carry_in;
      infl_last_ff <= infl_last_in;
      infl_ovf_ff  <= infl_ovf_in;
      rsp_pay_ff   <= rsp_pay_in;
   end

   // Element store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // An emit read must always land in an empty output register.
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      infl_ff |-> !rsp_valid_ff)
      else $error("emit read landed on an occupied output register");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("element count beyond capacity");

   a_pass_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) && rvld_ff |-> ridx_ff < limit_ff)
      else $error("sort pass read outside live range");

   a_last_closes_batch: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.payload.last |=> state_ff != ST_LOAD)
      else $error("last beat did not close the batch");

endmodule
